/* rtl/mhic_pkg.sv */
// ----------------------------------------------------------------------------
// Hard-iron calibrator package
// Shared types, op codes, register map and gain limit table for the
// three-axis min/max hard-iron calibrator.
// ----------------------------------------------------------------------------
package mhic_pkg;

  // Number of axes, one lane each.
  localparam int NumAxes = 3;

  // Sample and result field width.
  localparam int SampleW = 16;

  // APB register map: one 32-bit register at byte address 0.
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;
  localparam int RegIdxW  = ApbAddrW - 2;
  localparam logic [RegIdxW-1:0] RegGainCode = '0;

  // Gain code register width.
  localparam int GainCodeW = 3;

  // Calibration start values.
  localparam logic signed [SampleW-1:0] CalMinStart = 16'sd2000;
  localparam logic signed [SampleW-1:0] CalMaxStart = -16'sd2000;

  // Limit check scale factors.
  localparam int LimLowMul  = 243;
  localparam int LimHighMul = 575;
  localparam int LimDiv     = 390;

  // Counts per gauss for each gain code.
  localparam int GainCount0 = 1370;
  localparam int GainCount1 = 1090;
  localparam int GainCount2 = 820;
  localparam int GainCount3 = 660;
  localparam int GainCount4 = 440;
  localparam int GainCount5 = 390;
  localparam int GainCount6 = 330;
  localparam int GainCount7 = 230;

  // Operation codes carried with each sample.
  typedef enum logic [1:0] {
    OP_CORRECT = 2'd0,
    OP_BEGIN   = 2'd1,
    OP_UPDATE  = 2'd2,
    OP_END     = 2'd3
  } op_t;

  // Low and high self-test limits for the selected gain.
  typedef struct packed {
    logic signed [SampleW-1:0] lo;
    logic signed [SampleW-1:0] hi;
  } lim_t;

  // What one lane produces for the merging stage.
  typedef struct packed {
    logic signed [SampleW-1:0] corr;
    logic                      in_range;
  } lane_res_t;

  // Limit lookup; every arm is a constant folded at elaboration.
  function automatic lim_t gain_limits(logic [GainCodeW-1:0] code);
    lim_t lim;
    case (code)
      3'd0: begin
        lim.lo = 16'(LimLowMul * GainCount0 / LimDiv);
        lim.hi = 16'(LimHighMul * GainCount0 / LimDiv);
      end
      3'd1: begin
        lim.lo = 16'(LimLowMul * GainCount1 / LimDiv);
        lim.hi = 16'(LimHighMul * GainCount1 / LimDiv);
      end
      3'd2: begin
        lim.lo = 16'(LimLowMul * GainCount2 / LimDiv);
        lim.hi = 16'(LimHighMul * GainCount2 / LimDiv);
      end
      3'd3: begin
        lim.lo = 16'(LimLowMul * GainCount3 / LimDiv);
        lim.hi = 16'(LimHighMul * GainCount3 / LimDiv);
      end
      3'd4: begin
        lim.lo = 16'(LimLowMul * GainCount4 / LimDiv);
        lim.hi = 16'(LimHighMul * GainCount4 / LimDiv);
      end
      3'd5: begin
        lim.lo = 16'(LimLowMul * GainCount5 / LimDiv);
        lim.hi = 16'(LimHighMul * GainCount5 / LimDiv);
      end
      3'd6: begin
        lim.lo = 16'(LimLowMul * GainCount6 / LimDiv);
        lim.hi = 16'(LimHighMul * GainCount6 / LimDiv);
      end
      default: begin
        lim.lo = 16'(LimLowMul * GainCount7 / LimDiv);
        lim.hi = 16'(LimHighMul * GainCount7 / LimDiv);
      end
    endcase
    return lim;
  endfunction

endpackage

/* rtl/mhic_sample_if.sv */
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one raw three-axis sample and its op code.
// ----------------------------------------------------------------------------
interface mhic_sample_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [15:0] raw_x;
  logic signed [15:0] raw_y;
  logic signed [15:0] raw_z;

  modport source (output valid, output op, output raw_x, output raw_y,
                  output raw_z, input ready);
  modport sink (input valid, input op, input raw_x, input raw_y,
                input raw_z, output ready);
endinterface

/* rtl/mhic_result_if.sv */
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the corrected sample and its range flags.
// ----------------------------------------------------------------------------
interface mhic_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] corr_x;
  logic signed [15:0] corr_y;
  logic signed [15:0] corr_z;
  logic               in_range_x;
  logic               in_range_y;
  logic               in_range_z;

  modport source (output valid, output corr_x, output corr_y, output corr_z,
                  output in_range_x, output in_range_y, output in_range_z,
                  input ready);
  modport sink (input valid, input corr_x, input corr_y, input corr_z,
                input in_range_x, input in_range_y, input in_range_z,
                output ready);
endinterface

/* rtl/mhic_lane.sv */
// ----------------------------------------------------------------------------
// Calibrator axis lane
// Holds one axis' minimum, maximum and offset, applies the op of each
// accepted request and produces the corrected value and its range flag.
// ----------------------------------------------------------------------------
module mhic_lane
  import mhic_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  op_t                       op,
  input  logic signed [SampleW-1:0] raw,
  input  lim_t                      lim,
  output lane_res_t                 res
);

  logic signed [SampleW-1:0] min_val, min_val_next;
  logic signed [SampleW-1:0] max_val, max_val_next;
  logic signed [SampleW-1:0] offset, offset_next;
  logic signed [SampleW:0]   span;
  logic signed [SampleW:0]   half;
  logic signed [SampleW-1:0] mid;
  logic signed [SampleW-1:0] corr;

  // Midpoint of min and max, halving the span with truncation toward zero.
  always_comb begin
    span = {max_val[SampleW-1], max_val} - {min_val[SampleW-1], min_val};
    half = (span + {{SampleW{1'b0}}, span[SampleW]}) >>> 1;
    mid  = min_val + half[SampleW-1:0];
  end

  // Offset in force after this request, and the sample corrected by it.
  always_comb begin
    case (op)
      OP_BEGIN: offset_next = '0;
      OP_END:   offset_next = mid;
      default:  offset_next = offset;
    endcase
    corr = raw - offset_next;
  end

  // Extremes: restart on begin, fold the corrected value on update.
  always_comb begin
    min_val_next = min_val;
    max_val_next = max_val;
    case (op)
      OP_BEGIN: begin
        min_val_next = CalMinStart;
        max_val_next = CalMaxStart;
      end
      OP_UPDATE: begin
        if (corr < min_val) begin
          min_val_next = corr;
        end
        if (corr > max_val) begin
          max_val_next = corr;
        end
      end
      default: begin
        min_val_next = min_val;
        max_val_next = max_val;
      end
    endcase
  end

  // Lane state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_val <= CalMinStart;
      max_val <= CalMaxStart;
      offset  <= '0;
    end else if (accept) begin
      min_val <= min_val_next;
      max_val <= max_val_next;
      offset  <= offset_next;
    end
  end

  // Result toward the merging stage.
  assign res.corr     = corr;
  assign res.in_range = (corr > lim.lo) && (corr < lim.hi);

endmodule

/* rtl/mhic_merge.sv */
// ----------------------------------------------------------------------------
// Calibrator result merge
// Gathers the three lane results into one result request and holds it in
// an output register until the downstream side takes it.
// ----------------------------------------------------------------------------
module mhic_merge
  import mhic_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  lane_res_t            lane_res [NumAxes],
  output logic                 room,
  mhic_result_if.source        result
);

  logic valid;

  // A new request may enter when the register is empty or being drained.
  assign room = !valid || result.ready;

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (accept) begin
      result.corr_x     <= lane_res[0].corr;
      result.corr_y     <= lane_res[1].corr;
      result.corr_z     <= lane_res[2].corr;
      result.in_range_x <= lane_res[0].in_range;
      result.in_range_y <= lane_res[1].in_range;
      result.in_range_z <= lane_res[2].in_range;
    end
  end

  assign result.valid = valid;

endmodule

/* rtl/magnetometer_hard_iron_calibrator_core.sv */
// ----------------------------------------------------------------------------
// Magnetometer hard-iron calibrator
// Min/max hard-iron offset calibration for three axes with a gain based
// self-test range flag per corrected axis.
//
//   Channel   Direction  Handshake      Payload
//   sample    sink       valid/ready    op, raw_x, raw_y, raw_z
//   result    source     valid/ready    corr_x/y/z, in_range_x/y/z
//   apb       slave      psel/penable   gain_code at byte address 0
//
// One request is taken per cycle while the result is not stalled; its result
// is valid the cycle after. Each lane does its min/max/offset read-modify-write
// as the request is accepted. While a result is stalled, a new request is
// taken in the same cycle the result leaves. Synchronous reset clears the
// calibration state and gain_code; no clearing pass is needed.
// ----------------------------------------------------------------------------
module magnetometer_hard_iron_calibrator_core
  import mhic_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  mhic_sample_if.sink         sample,
  mhic_result_if.source       result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  logic [GainCodeW-1:0]      gain_code;
  logic                      cfg_write;
  logic                      room;
  logic                      accept;
  lim_t                      lim;
  op_t                       op;
  logic signed [SampleW-1:0] raw [NumAxes];
  lane_res_t                 lane_res [NumAxes];

  // Configuration register.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_code <= '0;
    end else if (cfg_write && (paddr[ApbAddrW-1:2] == RegGainCode)) begin
      gain_code <= pwdata[GainCodeW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[ApbAddrW-1:2] == RegGainCode) begin
      prdata = {{(ApbDataW-GainCodeW){1'b0}}, gain_code};
    end
  end

  // Request handshake and lane fan-out.
  assign sample.ready = room;
  assign accept       = sample.valid && room;
  assign op           = op_t'(sample.op);
  assign lim          = gain_limits(gain_code);
  assign raw[0]       = sample.raw_x;
  assign raw[1]       = sample.raw_y;
  assign raw[2]       = sample.raw_z;

  // One lane per axis.
  for (genvar a = 0; a < NumAxes; a++) begin : g_lane
    mhic_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .accept (accept),
      .op     (op),
      .raw    (raw[a]),
      .lim    (lim),
      .res    (lane_res[a])
    );
  end

  // Merge lanes into the result register.
  mhic_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .lane_res (lane_res),
    .room     (room),
    .result   (result)
  );

endmodule
